// File: src/assert_macros.svh
// assertion macros shared by the slip crc16 frame decoder
// no dependencies; expects a clock clk and an active low reset rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SCFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define SCFD_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/scfd_pkg.sv
// types and constants of the slip crc16 frame decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CIDX_W  = 2;
    localparam int FILL_W  = 2;

    localparam logic [BYTE_W-1:0] SLIP_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SLIP_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SLIP_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [WORD_W-1:0] MIN_END_INDEX = 16'd4;

    localparam logic [WORD_W-1:0] RST_MAX_FRAME   = 16'd256;
    localparam logic [WORD_W-1:0] RST_MAX_PAYLOAD = 16'd254;
    localparam logic [WORD_W-1:0] RST_CRC_POLY    = 16'h1021;
    localparam logic [WORD_W-1:0] RST_CRC_INIT    = 16'hFFFF;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        REG_MAX_FRAME   = 2'd0,
        REG_MAX_PAYLOAD = 2'd1,
        REG_CRC_POLY    = 2'd2,
        REG_CRC_INIT    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ESC  = 3'd1,
        ST_CRC      = 3'd2,
        ST_NO_START = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_TOO_LONG = 3'd5
    } status_t;

endpackage

`default_nettype wire

// File: src/slip_crc16_frame_decoder.sv
// slip deframer with trailing big-endian crc16 check, top level
// depends on scfd_pkg, scfd_crc_byte and assert_macros.svh
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    in_byte
//  out      source     out_valid/out_ready  kind, data_byte, status, payload_len, frame_last
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
// one byte per cycle while no result is held: a byte is registered on transfer, decoded
// against the frame state from the input register and its result, if any, lands in the
// output register
// reset clears the frame state except the hold bytes and loads the register defaults
// a held result stalls the byte in the input register, so in_ready drops until it moves
`timescale 1ns / 1ps
`default_nettype none

module slip_crc16_frame_decoder
    import scfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   in_byte,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     kind,
    output logic      [BYTE_W-1:0]   data_byte,
    output logic      [2:0]          status,
    output logic      [WORD_W-1:0]   payload_len,
    output logic                     frame_last,

    input  wire logic                cfg_we,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [WORD_W-1:0]   cfg_data
);

`include "assert_macros.svh"

    // configuration
    logic [WORD_W-1:0] max_frame_reg;
    logic [WORD_W-1:0] max_payload_reg;
    logic [WORD_W-1:0] crc_poly_reg;
    logic [WORD_W-1:0] crc_init_reg;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // frame state
    logic [WORD_W-1:0] raw_count_reg,  raw_count_next;
    logic              started_reg,    started_next;
    logic              in_escape_reg,  in_escape_next;
    status_t           frame_error_reg, frame_error_next;
    logic              discarding_reg, discarding_next;
    logic [BYTE_W-1:0] hold0_reg,      hold0_next;
    logic [BYTE_W-1:0] hold1_reg,      hold1_next;
    logic [FILL_W-1:0] hold_fill_reg,  hold_fill_next;
    logic [WORD_W-1:0] crc_reg,        crc_next;
    logic [WORD_W-1:0] dec_count_reg,  dec_count_next;

    // output stage
    logic              out_valid_reg;
    logic              kind_reg,       kind_next;
    logic [BYTE_W-1:0] data_byte_reg,  data_byte_next;
    status_t           status_reg,     status_next;
    logic [WORD_W-1:0] payload_len_reg, payload_len_next;
    logic              res_valid;

    logic              out_free;
    logic              fire;
    logic [WORD_W-1:0] crc_upd;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    scfd_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data    (hold0_reg),
        .poly    (crc_poly_reg),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        logic              bnd;
        logic              have_d;
        logic [BYTE_W-1:0] d;
        logic              emit;
        status_t           st;
        logic [WORD_W:0]   total;

        bnd    = (in_byte_reg == SLIP_END);
        have_d = 1'b0;
        d      = in_byte_reg;
        emit   = 1'b0;
        st     = ST_OK;
        total  = {1'b0, dec_count_reg} + {{(WORD_W-FILL_W+1){1'b0}}, hold_fill_reg}
                 + {{WORD_W{1'b0}}, 1'b1};

        raw_count_next   = raw_count_reg;
        started_next     = started_reg;
        in_escape_next   = in_escape_reg;
        frame_error_next = frame_error_reg;
        discarding_next  = discarding_reg;
        hold0_next       = hold0_reg;
        hold1_next       = hold1_reg;
        hold_fill_next   = hold_fill_reg;
        crc_next         = crc_reg;
        dec_count_next   = dec_count_reg;

        res_valid        = 1'b0;
        kind_next        = KIND_DATA;
        data_byte_next   = '0;
        status_next      = ST_OK;
        payload_len_next = '0;

        if (discarding_reg)
        begin
            if (bnd)
            begin
                emit = 1'b1;
                st   = ST_OVERFLOW;
            end
        end
        else if (raw_count_reg >= max_frame_reg)
        begin
            if (bnd)
            begin
                emit = 1'b1;
                st   = ST_OVERFLOW;
            end
            else
            begin
                discarding_next  = 1'b1;
                frame_error_next = ST_OVERFLOW;
            end
        end
        else if (bnd)
        begin
            if (raw_count_reg <= MIN_END_INDEX)
            begin
                raw_count_next   = 16'd1;
                started_next     = 1'b1;
                in_escape_next   = 1'b0;
                frame_error_next = ST_OK;
                discarding_next  = 1'b0;
                hold_fill_next   = '0;
                crc_next         = crc_init_reg;
                dec_count_next   = '0;
            end
            else
            begin
                emit = 1'b1;
                priority if (!started_reg)
                    st = ST_NO_START;
                else if (frame_error_reg != ST_OK)
                    st = frame_error_reg;
                else if (in_escape_reg)
                    st = ST_BAD_ESC;
                else if (hold_fill_reg < 2'd2)
                    st = ST_CRC;
                else if (crc_reg != {hold0_reg, hold1_reg})
                    st = ST_CRC;
                else
                    st = ST_OK;
            end
        end
        else
        begin
            raw_count_next = raw_count_reg + 16'd1;
            if (started_reg && frame_error_reg == ST_OK)
            begin
                if (in_escape_reg)
                begin
                    in_escape_next = 1'b0;
                    priority if (in_byte_reg == SLIP_ESC_END)
                    begin
                        d      = SLIP_END;
                        have_d = 1'b1;
                    end
                    else if (in_byte_reg == SLIP_ESC_ESC)
                    begin
                        d      = SLIP_ESC;
                        have_d = 1'b1;
                    end
                    else
                    begin
                        frame_error_next = ST_BAD_ESC;
                    end
                end
                else if (in_byte_reg == SLIP_ESC)
                begin
                    in_escape_next = 1'b1;
                end
                else
                begin
                    have_d = 1'b1;
                end

                if (have_d)
                begin
                    if (total > {1'b0, max_payload_reg})
                    begin
                        frame_error_next = ST_TOO_LONG;
                    end
                    else if (hold_fill_reg == 2'd0)
                    begin
                        hold0_next     = d;
                        hold_fill_next = 2'd1;
                    end
                    else if (hold_fill_reg == 2'd1)
                    begin
                        hold1_next     = d;
                        hold_fill_next = 2'd2;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        data_byte_next = hold0_reg;
                        crc_next       = crc_upd;
                        hold0_next     = hold1_reg;
                        hold1_next     = d;
                        dec_count_next = dec_count_reg + 16'd1;
                    end
                end
            end
        end

        if (emit)
        begin
            res_valid        = 1'b1;
            kind_next        = KIND_STATUS;
            status_next      = st;
            payload_len_next = dec_count_reg;
            raw_count_next   = '0;
            started_next     = 1'b0;
            in_escape_next   = 1'b0;
            frame_error_next = ST_OK;
            discarding_next  = 1'b0;
            hold_fill_next   = '0;
            crc_next         = crc_init_reg;
            dec_count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg   <= RST_MAX_FRAME;
            max_payload_reg <= RST_MAX_PAYLOAD;
            crc_poly_reg    <= RST_CRC_POLY;
            crc_init_reg    <= RST_CRC_INIT;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAX_FRAME:   max_frame_reg   <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                REG_CRC_INIT:    crc_init_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_count_reg   <= '0;
            started_reg     <= 1'b0;
            in_escape_reg   <= 1'b0;
            frame_error_reg <= ST_OK;
            discarding_reg  <= 1'b0;
            hold_fill_reg   <= '0;
            crc_reg         <= RST_CRC_INIT;
            dec_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                raw_count_reg   <= raw_count_next;
                started_reg     <= started_next;
                in_escape_reg   <= in_escape_next;
                frame_error_reg <= frame_error_next;
                discarding_reg  <= discarding_next;
                hold_fill_reg   <= hold_fill_next;
                crc_reg         <= crc_next;
                dec_count_reg   <= dec_count_next;
            end
            if (fire && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
        end
        if (fire && res_valid)
        begin
            kind_reg        <= kind_next;
            data_byte_reg   <= data_byte_next;
            status_reg      <= status_next;
            payload_len_reg <= payload_len_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_byte_reg;
    assign status      = status_reg;
    assign payload_len = payload_len_reg;
    assign frame_last  = kind_reg;

    `SCFD_ASSERT(a_discard_err, discarding_reg |-> (frame_error_reg == ST_OVERFLOW), "discard without overflow error")
    `SCFD_ASSERT_NEVER(a_fill_range, hold_fill_reg > 2'd2, "hold fill out of range")
    `SCFD_ASSERT(a_emit_full, (dec_count_reg != '0) |-> (hold_fill_reg == 2'd2), "data emitted with pipe not full")
    `SCFD_ASSERT(a_stall_hold, (in_valid_reg && !out_free) |=> in_valid_reg, "stalled byte lost")

endmodule

`default_nettype wire

// File: src/scfd_crc_byte.sv
// one byte of msb-first crc16 update with a programmable polynomial
// depends on scfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfd_crc_byte
    import scfd_pkg::*;
(
    input  wire logic [WORD_W-1:0] crc_in,
    input  wire logic [BYTE_W-1:0] data,
    input  wire logic [WORD_W-1:0] poly,
    output logic      [WORD_W-1:0] crc_out
);

    always_comb
    begin
        logic [WORD_W-1:0] c;
        c = crc_in ^ {data, {(WORD_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[WORD_W-1])
            begin
                c = {c[WORD_W-2:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the slip crc16 frame decoder: random and directed line bytes,
// an in-bench decoder that predicts every data and status transfer, random idling on both sides
// depends on scfd_pkg and slip_crc16_frame_decoder

module tb_top;
    import scfd_pkg::*;

    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned SETTLE_WAIT  = 8;
    localparam int unsigned PRINT_LIMIT  = 200;

    typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;
    typedef enum int {FL_GOOD, FL_BAD_CRC, FL_BAD_ESC, FL_OPEN_ESC, FL_NO_START} frame_flavor_t;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [2:0]        status;
        logic [WORD_W-1:0] payload_len;
        logic              frame_last;
    } dec_item_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [2:0]          status;
    logic [WORD_W-1:0]   payload_len;
    logic                frame_last;
    logic                cfg_we = 1'b0;
    reg_idx_t            cfg_index = REG_MAX_FRAME;
    logic [WORD_W-1:0]   cfg_data = '0;

    // line bytes waiting to be sent and decoder results still due
    logic [BYTE_W-1:0]   line_bytes[$];
    dec_item_t           due_items[$];
    int unsigned         stim_bytes = 0;
    int unsigned         mismatches = 0;

    idle_mode_t          tx_mode = IDLE_NONE;
    idle_mode_t          rx_mode = IDLE_NONE;
    int unsigned         tx_wait;
    int unsigned         rx_gap;
    int unsigned         rx_hold;
    int unsigned         rx_gap_next;
    int unsigned         rx_hold_next;
    int unsigned         hold_requests = 0;
    int unsigned         holds_taken;
    int unsigned         stuck_cycles = 0;

    // decoder copy: configuration and frame state
    logic [WORD_W-1:0]   frame_cap;
    logic [WORD_W-1:0]   payload_cap;
    logic [WORD_W-1:0]   crc_poly_cfg;
    logic [WORD_W-1:0]   crc_init_cfg;
    logic [WORD_W-1:0]   cnt_raw;
    logic                in_frame;
    logic                esc_open;
    status_t             first_err;
    logic                dropping;
    logic [BYTE_W-1:0]   held[2];
    logic [1:0]          held_n;
    logic [WORD_W-1:0]   crc_acc;
    logic [WORD_W-1:0]   emitted;

    slip_crc16_frame_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .status      (status),
        .payload_len (payload_len),
        .frame_last  (frame_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [WORD_W-1:0] p);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ p) : (c << 1);
        return c;
    endfunction

    function automatic void clear_decoder();
        cnt_raw   = '0;
        in_frame  = 1'b0;
        esc_open  = 1'b0;
        first_err = ST_OK;
        dropping  = 1'b0;
        held[0]   = '0;
        held[1]   = '0;
        held_n    = '0;
        crc_acc   = crc_init_cfg;
        emitted   = '0;
    endfunction

    function automatic void close_frame(input status_t st);
        dec_item_t item;
        item.kind        = KIND_STATUS;
        item.data_byte   = '0;
        item.status      = st;
        item.payload_len = emitted;
        item.frame_last  = 1'b1;
        due_items.push_back(item);
        clear_decoder();
    endfunction

    function automatic void decode_line_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        logic              is_end;
        dec_item_t         item;
        is_end = (b == SLIP_END);
        if (dropping)
        begin
            if (is_end)
                close_frame(ST_OVERFLOW);
            return;
        end
        if (cnt_raw >= frame_cap)
        begin
            if (is_end)
                close_frame(ST_OVERFLOW);
            else
            begin
                dropping  = 1'b1;
                first_err = ST_OVERFLOW;
            end
            return;
        end
        if (is_end)
        begin
            if (cnt_raw <= MIN_END_INDEX)
            begin
                clear_decoder();
                in_frame = 1'b1;
                cnt_raw  = 16'd1;
            end
            else if (!in_frame)
                close_frame(ST_NO_START);
            else if (first_err != ST_OK)
                close_frame(first_err);
            else if (esc_open)
                close_frame(ST_BAD_ESC);
            else if (held_n < 2 || crc_acc != {held[0], held[1]})
                close_frame(ST_CRC);
            else
                close_frame(ST_OK);
            return;
        end
        cnt_raw = cnt_raw + 16'd1;
        if (!in_frame || first_err != ST_OK)
            return;
        if (esc_open)
        begin
            esc_open = 1'b0;
            if (b == SLIP_ESC_END)
                d = SLIP_END;
            else if (b == SLIP_ESC_ESC)
                d = SLIP_ESC;
            else
            begin
                first_err = ST_BAD_ESC;
                return;
            end
        end
        else if (b == SLIP_ESC)
        begin
            esc_open = 1'b1;
            return;
        end
        else
            d = b;
        if ({16'd0, emitted} + held_n + 32'd1 > {16'd0, payload_cap})
        begin
            first_err = ST_TOO_LONG;
            return;
        end
        if (held_n < 2)
        begin
            held[held_n[0]] = d;
            held_n = held_n + 2'd1;
            return;
        end
        item.kind        = KIND_DATA;
        item.data_byte   = held[0];
        item.status      = ST_OK;
        item.payload_len = '0;
        item.frame_last  = 1'b0;
        due_items.push_back(item);
        crc_acc = crc16_step(crc_acc, held[0], crc_poly_cfg);
        held[0] = held[1];
        held[1] = d;
        emitted = emitted + 16'd1;
    endfunction

    function automatic int unsigned idle_draw(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic void report_field(input string field, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endfunction

    function automatic void check_result();
        dec_item_t want;
        if (due_items.size() == 0)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: unexpected result: kind %0h data %0h status %0h len %0h last %0h",
                         $time, kind, data_byte, status, payload_len, frame_last);
            return;
        end
        want = due_items.pop_front();
        if (kind !== want.kind)
            report_field("kind", want.kind, kind);
        if (data_byte !== want.data_byte)
            report_field("data_byte", want.data_byte, data_byte);
        if (status !== want.status)
            report_field("status", want.status, status);
        if (payload_len !== want.payload_len)
            report_field("payload_len", want.payload_len, payload_len);
        if (frame_last !== want.frame_last)
            report_field("frame_last", want.frame_last, frame_last);
    endfunction

    // sender: one byte per transfer, random wait after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= '0;
            tx_wait  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_line_byte(in_byte);
            if (!in_valid || in_ready)
            begin
                if (tx_wait != 0)
                begin
                    in_valid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end
                else if (line_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= line_bytes.pop_front();
                    tx_wait  <= idle_draw(tx_mode);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer, random ready gaps and an occasional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            rx_gap      <= 0;
            rx_hold     <= 0;
            holds_taken <= 0;
        end
        else
        begin
            rx_gap_next  = rx_gap;
            rx_hold_next = rx_hold;
            if (out_valid && out_ready)
            begin
                check_result();
                rx_gap_next = idle_draw(rx_mode);
            end
            else if (rx_hold_next != 0)
                rx_hold_next = rx_hold_next - 1;
            else if (rx_gap_next != 0)
                rx_gap_next = rx_gap_next - 1;
            if (holds_taken != hold_requests)
            begin
                rx_hold_next = LONG_HOLD;
                holds_taken  <= hold_requests;
            end
            rx_gap    <= rx_gap_next;
            rx_hold   <= rx_hold_next;
            out_ready <= (rx_gap_next == 0 && rx_hold_next == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    function automatic void queue_byte(input logic [BYTE_W-1:0] b);
        line_bytes.push_back(b);
        stim_bytes++;
    endfunction

    function automatic void queue_coded(input logic [BYTE_W-1:0] b);
        if (b == SLIP_END)
        begin
            queue_byte(SLIP_ESC);
            queue_byte(SLIP_ESC_END);
        end
        else if (b == SLIP_ESC)
        begin
            queue_byte(SLIP_ESC);
            queue_byte(SLIP_ESC_ESC);
        end
        else
            queue_byte(b);
    endfunction

    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return SLIP_END;
            1:       return SLIP_ESC;
            2:       return $urandom_range(0, 1) ? SLIP_ESC_END : SLIP_ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] bad_escape_byte();
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == SLIP_ESC_END || b == SLIP_ESC_ESC);
        return b;
    endfunction

    // payload plus big-endian crc, escaped and framed, with an optional defect
    function automatic void add_frame(input logic [BYTE_W-1:0] payload[$],
                                      input frame_flavor_t flavor);
        logic [BYTE_W-1:0] body[$];
        logic [WORD_W-1:0] crc;
        int unsigned       cut;
        body = payload;
        crc  = crc_init_cfg;
        foreach (payload[i])
            crc = crc16_step(crc, payload[i], crc_poly_cfg);
        if (flavor == FL_BAD_CRC)
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        cut = $urandom_range(0, body.size() - 1);
        if (flavor != FL_NO_START)
            queue_byte(SLIP_END);
        foreach (body[i])
        begin
            if (flavor == FL_BAD_ESC && i == cut)
            begin
                queue_byte(SLIP_ESC);
                queue_byte(bad_escape_byte());
            end
            queue_coded(body[i]);
        end
        if (flavor == FL_OPEN_ESC)
            queue_byte(SLIP_ESC);
        queue_byte(SLIP_END);
    endfunction

    function automatic void add_random_frame();
        logic [BYTE_W-1:0] body[$];
        int                len;
        int unsigned       pick;
        frame_flavor_t     flavor;
        pick   = $urandom_range(0, 99);
        len    = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 40))
                                             : int'($urandom_range(0, 12));
        flavor = FL_GOOD;
        if (pick < 62)
            flavor = FL_GOOD;
        else if (pick < 68)
            flavor = FL_BAD_CRC;
        else if (pick < 73)
            flavor = FL_BAD_ESC;
        else if (pick < 76)
            flavor = FL_OPEN_ESC;
        else if (pick < 80)
            flavor = FL_NO_START;
        else if (pick < 86)
        begin
            // loose line noise with stray boundaries
            repeat ($urandom_range(1, 8))
                queue_byte(payload_byte());
            return;
        end
        else if (pick < 92)
        begin
            if (frame_cap <= 60)
                len = int'(frame_cap) - 5 + int'($urandom_range(0, 3));
        end
        else if (payload_cap <= 60)
            len = int'(payload_cap) - 3 + int'($urandom_range(0, 2));
        if (len < 0)
            len = 0;
        repeat (len)
            body.push_back(payload_byte());
        add_frame(body, flavor);
    endfunction

    function automatic void add_big_frame(input int unsigned len);
        logic [BYTE_W-1:0] body[$];
        repeat (len)
            body.push_back(8'($urandom_range(0, 8'hBF)));
        add_frame(body, FL_GOOD);
    endfunction

    task automatic settle();
        do
            @(posedge clk);
        while (line_bytes.size() != 0 || in_valid || due_items.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [WORD_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [WORD_W-1:0] mf, input logic [WORD_W-1:0] mp,
                             input logic [WORD_W-1:0] poly, input logic [WORD_W-1:0] init,
                             input int unsigned n_bytes, input idle_mode_t txm,
                             input idle_mode_t rxm, input bit long_hold);
        int unsigned mark;
        settle();
        write_reg(REG_MAX_FRAME, mf);
        write_reg(REG_MAX_PAYLOAD, mp);
        write_reg(REG_CRC_POLY, poly);
        write_reg(REG_CRC_INIT, init);
        frame_cap    = mf;
        payload_cap  = mp;
        crc_poly_cfg = poly;
        crc_init_cfg = init;
        tx_mode      = txm;
        rx_mode      = rxm;
        mark         = stim_bytes;
        while (stim_bytes - mark < n_bytes)
            add_random_frame();
        if (long_hold)
            hold_requests++;
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] seed_bytes[$];
        frame_cap    = RST_MAX_FRAME;
        payload_cap  = RST_MAX_PAYLOAD;
        crc_poly_cfg = RST_CRC_POLY;
        crc_init_cfg = RST_CRC_INIT;
        clear_decoder();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // byte extremes and both escape pairs in a clean frame
        seed_bytes = {8'h00, 8'hFF, SLIP_END, SLIP_ESC};
        add_frame(seed_bytes, FL_GOOD);
        // bytes with no start boundary
        queue_byte(8'h11);
        queue_byte(8'h22);
        queue_byte(8'h33);
        queue_byte(8'h44);
        queue_byte(8'h55);
        queue_byte(SLIP_END);
        // escape followed by a wrong byte, then an escape left open at the end
        seed_bytes.delete();
        add_frame(seed_bytes, FL_BAD_ESC);
        seed_bytes = {8'h3C};
        add_frame(seed_bytes, FL_OPEN_ESC);
        // back-to-back boundaries restart the frame
        queue_byte(SLIP_END);
        queue_byte(SLIP_END);

        run_phase(RST_MAX_FRAME, RST_MAX_PAYLOAD, RST_CRC_POLY, RST_CRC_INIT, 160,
                  IDLE_SPARSE, IDLE_SPARSE, 1'b0);
        run_phase(16'd6, 16'd1, RST_CRC_POLY, RST_CRC_INIT, 90, IDLE_FULL, IDLE_NONE, 1'b0);
        run_phase(16'd3, RST_MAX_PAYLOAD, RST_CRC_POLY, RST_CRC_INIT, 40,
                  IDLE_NONE, IDLE_FULL, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 110, IDLE_FULL, IDLE_FULL, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 80, IDLE_NONE, IDLE_NONE, 1'b0);
        run_phase(16'd24, 16'd12, 16'h8005, 16'h1D0F, 110, IDLE_SPARSE, IDLE_FULL, 1'b0);
        run_phase(16'd48, 16'd30, 16'($urandom_range(0, 16'hFFFF)),
                  16'($urandom_range(0, 16'hFFFF)), 110, IDLE_FULL, IDLE_SPARSE, 1'b1);
        run_phase(16'd300, RST_MAX_PAYLOAD, RST_CRC_POLY, RST_CRC_INIT, 30,
                  IDLE_SPARSE, IDLE_SPARSE, 1'b0);
        // a payload that fits, one past the payload limit, and one beyond the raw capacity
        add_big_frame(250);
        add_big_frame(253);
        add_big_frame(320);

        settle();
        if (mismatches == 0 && due_items.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: slip_crc16_frame_decoder.f
+incdir+src
src/scfd_pkg.sv
src/scfd_crc_byte.sv
src/slip_crc16_frame_decoder.sv
verif/tb_top.sv
